@@ design/tce_pkg.sv @@
// ----------------------------------------------------------------------------
// tce_pkg - text console engine shared definitions
// Cell layout, field widths, control character codes, operation codes and
// the sequencer state type used by the console modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

	// default geometry
	localparam int COLS_DEF     = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 4;

	// payload field widths
	localparam int FUNC_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 4;
	localparam int SEL_W   = 8;
	localparam int CROW_W  = 5;
	localparam int CCOL_W  = 7;
	localparam int CPOS_W  = 11;
	localparam int CFG_IDX_W = 1;

	// control characters
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

	// reset colours: grey on black
	localparam logic [COLOR_W-1:0] FORE_RST = 4'd7;
	localparam logic [COLOR_W-1:0] BACK_RST = 4'd0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FORE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACK = 1'd1;

	// one character cell as stored
	typedef struct packed {
		logic [COLOR_W-1:0] back;
		logic [COLOR_W-1:0] fore;
		logic [CHAR_W-1:0]  code;
	} cell_t;

	localparam cell_t BLANK_RST = '{back: BACK_RST, fore: FORE_RST, code: CH_SPACE};

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		FN_PUT  = 2'd0,
		FN_SET  = 2'd1,
		FN_CLR  = 2'd2,
		FN_READ = 2'd3
	} func_t;

	// what follows the address computation
	typedef enum logic [1:0] {
		ACC_READ,
		ACC_WRITE1,
		ACC_TAB,
		ACC_ROW
	} acc_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DEC,
		S_TMOD,
		S_ADDR,
		S_ADDR2,
		S_RD,
		S_RDW,
		S_WR1,
		S_TWR,
		S_NL,
		S_ROW,
		S_CLR,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

@@ design/tce_cell_ram.sv @@
// ----------------------------------------------------------------------------
// tce_cell_ram - character cell store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  wire logic           clk,
	input  wire logic           we,
	input  wire logic [AW-1:0]  waddr,
	input  wire tce_pkg::cell_t wdata,
	input  wire logic [AW-1:0]  raddr,
	output tce_pkg::cell_t      rdata
);
	import tce_pkg::*;

	cell_t mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ design/text_console_engine_top.sv @@
// ----------------------------------------------------------------------------
// text_console_engine_top - character grid console with cursor
// Put character (with newline, return, tab, backspace), set cursor, clear
// screen and read cell on a ROWS x COLS grid of colour character cells.
//
// Usage:
//  - Input channel (in_valid/in_stall) takes one command item; the output
//    channel (out_valid/out_stall) returns exactly one result item for it.
//  - Colours are set through the write port (cfg_we, cfg_index, cfg_data),
//    index 0 foreground, index 1 background. The user must write them only
//    while the block is idle; the block itself does not enforce this.
//  - Passing the last row blanks the new bottom row (scrolling moves a
//    top-row pointer instead of copying).
//  - One item at a time: in_stall is high from acceptance until the result
//    is loaded into the output register. A result still held by out_stall
//    does not block taking the next item; only its own result waits.
//  - After reset the grid is swept to blanks, grey on black, one cell a
//    cycle over all ROWS*COLS cells (2000 by default) with in_stall high.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_engine_top #(
	parameter int COLS     = tce_pkg::COLS_DEF,
	parameter int ROWS     = tce_pkg::ROWS_DEF,
	parameter int TAB_STOP = tce_pkg::TAB_STOP_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [tce_pkg::FUNC_W-1:0]     func,
	input  wire logic [tce_pkg::CHAR_W-1:0]     char_code,
	input  wire logic [tce_pkg::SEL_W-1:0]      row_sel,
	input  wire logic [tce_pkg::SEL_W-1:0]      col_sel,
	// output channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [tce_pkg::CHAR_W-1:0]          cell_char,
	output logic [tce_pkg::COLOR_W-1:0]         cell_fore,
	output logic [tce_pkg::COLOR_W-1:0]         cell_back,
	output logic [tce_pkg::CROW_W-1:0]          cursor_row,
	output logic [tce_pkg::CCOL_W-1:0]          cursor_col,
	output logic [tce_pkg::CPOS_W-1:0]          cursor_pos,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [tce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tce_pkg::COLOR_W-1:0]    cfg_data
);
	import tce_pkg::*;

	localparam int CELLS = ROWS * COLS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS);
	localparam int TW    = $clog2(TAB_STOP + 1);
	localparam int REM_W = (CW > TW) ? CW : TW;

	localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);
	localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);
	localparam logic [RW:0]   ROWS_X    = (RW + 1)'(ROWS);
	localparam logic [REM_W-1:0] TAB_X  = REM_W'(TAB_STOP);

	// sequencer and datapath registers
	state_t state_q, state_d;
	func_t  func_q;
	acc_t   acc_q;
	logic [CHAR_W-1:0]  ch_q;
	logic [SEL_W-1:0]   rsel_q, csel_q;
	logic [RW-1:0]      row_q, top_q, prow_q, tgt_row_q;
	logic [CW-1:0]      col_q, tgt_col_q;
	logic [AW-1:0]      addr_q;
	logic [CHAR_W-1:0]  wchar_q;
	logic               adv_q;
	logic [REM_W-1:0]   rem_q;
	logic [TW-1:0]      cnt_q;
	cell_t              res_cell_q;
	logic [COLOR_W-1:0] fore_q, back_q;

	// output register
	logic               out_valid_q;
	logic [CHAR_W-1:0]  cell_char_q;
	logic [COLOR_W-1:0] cell_fore_q, cell_back_q;
	logic [CROW_W-1:0]  cursor_row_q;
	logic [CCOL_W-1:0]  cursor_col_q;
	logic [CPOS_W-1:0]  cursor_pos_q;

	// cell store port
	logic        mem_we;
	cell_t       mem_wdata;
	cell_t       mem_rdata;

	tce_cell_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(addr_q),
		.wdata(mem_wdata),
		.raddr(addr_q),
		.rdata(mem_rdata)
	);

	// derived values
	logic [RW-1:0] row_clamp, bs_row;
	logic [CW-1:0] col_clamp, bs_col;
	logic [RW:0]   prow_sum;
	logic          out_free;
	cell_t         blank_cur;

	always_comb begin
		row_clamp = (rsel_q >= SEL_W'(ROWS)) ? ROW_LAST : rsel_q[RW-1:0];
		col_clamp = (csel_q >= SEL_W'(COLS)) ? COL_LAST : csel_q[CW-1:0];
		// backspace target: back one column, or up to the end of the row above
		bs_row = row_q;
		bs_col = col_q;
		if (col_q != '0) begin
			bs_col = col_q - 1'b1;
		end else if (row_q != '0) begin
			bs_row = row_q - 1'b1;
			bs_col = COL_LAST;
		end
		// logical row to physical row through the scroll pointer
		prow_sum = {1'b0, tgt_row_q} + {1'b0, top_q};
		if (prow_sum >= ROWS_X) begin
			prow_sum = prow_sum - ROWS_X;
		end
		out_free  = !out_valid_q || !out_stall;
		blank_cur = '{back: back_q, fore: fore_q, code: CH_SPACE};
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory write control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_wdata = blank_cur;
		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = BLANK_RST;
				if (addr_q == ADDR_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				unique case (func_q)
					FN_PUT: begin
						if (ch_q == CH_NEWLINE) begin
							state_d = S_NL;
						end else if (ch_q == CH_RETURN) begin
							state_d = S_DONE;
						end else if (ch_q == CH_TAB) begin
							state_d = S_TMOD;
						end else begin
							state_d = S_ADDR;
						end
					end
					FN_SET:  state_d = S_DONE;
					FN_CLR:  state_d = S_CLR;
					FN_READ: state_d = S_ADDR;
					default: state_d = S_DONE;
				endcase
			end
			S_TMOD: begin
				if (rem_q < TAB_X) begin
					state_d = S_ADDR;
				end
			end
			S_ADDR: state_d = S_ADDR2;
			S_ADDR2: begin
				unique case (acc_q)
					ACC_READ:   state_d = S_RD;
					ACC_WRITE1: state_d = S_WR1;
					ACC_TAB:    state_d = S_TWR;
					ACC_ROW:    state_d = S_ROW;
					default:    state_d = S_DONE;
				endcase
			end
			S_RD:  state_d = S_RDW;
			S_RDW: state_d = S_DONE;
			S_WR1: begin
				mem_we    = 1'b1;
				mem_wdata = '{back: back_q, fore: fore_q, code: wchar_q};
				state_d   = (adv_q && col_q == COL_LAST) ? S_NL : S_DONE;
			end
			S_TWR: begin
				mem_we = 1'b1;
				if (col_q == COL_LAST) begin
					state_d = S_NL;
				end else if (cnt_q == TW'(1)) begin
					state_d = S_DONE;
				end
			end
			S_NL: begin
				state_d = (row_q == ROW_LAST) ? S_ADDR2 : S_DONE;
			end
			S_ROW: begin
				mem_we = 1'b1;
				if (tgt_col_q == COL_LAST) begin
					state_d = S_DONE;
				end
			end
			S_CLR: begin
				mem_we = 1'b1;
				if (addr_q == ADDR_LAST) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control datapath: cursor, scroll pointer, sweep address, colours
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			top_q  <= '0;
			addr_q <= '0;
			fore_q <= FORE_RST;
			back_q <= BACK_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FORE: fore_q <= cfg_data;
					REG_BACK: back_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_INIT, S_CLR, S_ROW, S_TWR: addr_q <= addr_q + 1'b1;
				S_DEC: begin
					case (func_q)
						FN_PUT: begin
							if (ch_q == CH_RETURN) begin
								col_q <= '0;
							end else if (ch_q == CH_BACKSPACE) begin
								row_q <= bs_row;
								col_q <= bs_col;
							end
						end
						FN_SET: begin
							row_q <= row_clamp;
							col_q <= col_clamp;
						end
						FN_CLR: begin
							row_q  <= '0;
							col_q  <= '0;
							top_q  <= '0;
							addr_q <= '0;
						end
						default: ;
					endcase
				end
				S_ADDR2: addr_q <= AW'(32'(prow_q) * 32'(COLS) + 32'(tgt_col_q));
				default: ;
			endcase
			// cursor advance after a write
			if (state_q == S_WR1 && adv_q && col_q != COL_LAST) begin
				col_q <= col_q + 1'b1;
			end
			if (state_q == S_TWR && col_q != COL_LAST) begin
				col_q <= col_q + 1'b1;
			end
			// new line; on the last row the top pointer moves down one
			if (state_q == S_NL) begin
				col_q <= '0;
				if (row_q != ROW_LAST) begin
					row_q <= row_q + 1'b1;
				end else begin
					top_q <= (top_q == ROW_LAST) ? '0 : top_q + 1'b1;
				end
			end
		end
	end

	// payload datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= func_t'(func);
				ch_q   <= char_code;
				rsel_q <= row_sel;
				csel_q <= col_sel;
			end
			S_DEC: begin
				res_cell_q <= '0;
				rem_q      <= REM_W'(col_q);
				if (func_q == FN_READ) begin
					tgt_row_q <= row_clamp;
					tgt_col_q <= col_clamp;
					wchar_q   <= ch_q;
					adv_q     <= 1'b1;
					acc_q     <= ACC_READ;
				end else if (ch_q == CH_BACKSPACE) begin
					tgt_row_q <= bs_row;
					tgt_col_q <= bs_col;
					wchar_q   <= CH_SPACE;
					adv_q     <= 1'b0;
					acc_q     <= ACC_WRITE1;
				end else begin
					tgt_row_q <= row_q;
					tgt_col_q <= col_q;
					wchar_q   <= ch_q;
					adv_q     <= 1'b1;
					acc_q     <= ACC_WRITE1;
				end
			end
			S_TMOD: begin
				// column modulo the tab stop by repeated subtraction
				if (rem_q >= TAB_X) begin
					rem_q <= rem_q - TAB_X;
				end else begin
					cnt_q <= TW'(TAB_X - rem_q);
					acc_q <= ACC_TAB;
				end
			end
			S_ADDR: prow_q <= prow_sum[RW-1:0];
			S_TWR:  cnt_q  <= cnt_q - 1'b1;
			S_NL: begin
				// bottom row to blank is the old top row
				prow_q    <= top_q;
				tgt_col_q <= '0;
				acc_q     <= ACC_ROW;
			end
			S_ROW: tgt_col_q <= tgt_col_q + 1'b1;
			S_RDW: res_cell_q <= mem_rdata;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			cell_char_q  <= res_cell_q.code;
			cell_fore_q  <= res_cell_q.fore;
			cell_back_q  <= res_cell_q.back;
			cursor_row_q <= CROW_W'(row_q);
			cursor_col_q <= CCOL_W'(col_q);
			cursor_pos_q <= CPOS_W'(32'(row_q) * 32'(COLS) + 32'(col_q));
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign cell_char  = cell_char_q;
	assign cell_fore  = cell_fore_q;
	assign cell_back  = cell_back_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;
	assign cursor_pos = cursor_pos_q;

	// cursor and scroll pointer stay inside the grid
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(row_q) < ROWS) && (int'(col_q) < COLS) && (int'(top_q) < ROWS))
		else $error("cursor or top row out of range");

	// an accepted item is decoded in the next cycle
	a_accept_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DEC))
		else $error("accepted item not decoded");

	// row blanking walks the row one cell a cycle
	a_row_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROW && tgt_col_q != COL_LAST) |=>
		(state_q == S_ROW && addr_q == $past(addr_q) + 1'b1))
		else $error("row blanking sweep broken");

	// a pending result is never overwritten by the next one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> (state_q == S_DONE))
		else $error("result loaded while output held");

endmodule

`default_nettype wire

@@ tb/sv/tb_text_console_engine_top.sv @@
// ----------------------------------------------------------------------------
// tb_text_console_engine_top - self-checking bench for the text console
// Drives put character, set cursor, clear and read cell commands through the
// valid/stall input channel and checks every result item against a software
// copy of the character grid and cursor. The run walks through several
// colour settings and sender/receiver idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_console_engine_top;
	import tce_pkg::*;

	localparam int COLS       = COLS_DEF;
	localparam int ROWS       = ROWS_DEF;
	localparam int TAB_STOP   = TAB_STOP_DEF;
	localparam int CELLS      = ROWS * COLS;
	localparam int IDLE_LIMIT = 20000;
	localparam int PHASES     = 8;
	localparam int PER_PHASE  = 225;

	// what one result item carries
	typedef struct {
		logic [CHAR_W-1:0]  code;
		logic [COLOR_W-1:0] fore;
		logic [COLOR_W-1:0] back;
		logic [CROW_W-1:0]  row;
		logic [CCOL_W-1:0]  col;
		logic [CPOS_W-1:0]  pos;
	} console_view_t;

	// mirror of the grid and cursor plus the queue of views still owed
	class console_scoreboard;
		cell_t         screen[CELLS];
		int            row_now;
		int            col_now;
		logic [3:0]    fore_now;
		logic [3:0]    back_now;
		console_view_t owed[$];
		int            mismatches;
		int            commands;
		int            results;
		int            reads;
		int            scrolls;
		int            clears;

		function new();
			fore_now = FORE_RST;
			back_now = BACK_RST;
			foreach (screen[i])
				screen[i] = BLANK_RST;
			row_now = 0;
			col_now = 0;
		endfunction

		function void set_colour(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] value);
			if (idx == REG_FORE)
				fore_now = value;
			else if (idx == REG_BACK)
				back_now = value;
		endfunction

		function cell_t make_cell(logic [CHAR_W-1:0] ch);
			return '{back: back_now, fore: fore_now, code: ch};
		endfunction

		function void new_line();
			col_now = 0;
			row_now++;
			if (row_now >= ROWS) begin
				// scroll up one row, blank the bottom row in the current colours
				for (int i = 0; i + COLS < CELLS; i++)
					screen[i] = screen[i + COLS];
				for (int c = 0; c < COLS; c++)
					screen[(ROWS - 1) * COLS + c] = make_cell(CH_SPACE);
				row_now = ROWS - 1;
				scrolls++;
			end
		endfunction

		function void put_char(logic [CHAR_W-1:0] ch);
			int stop;
			if (ch == CH_NEWLINE) begin
				new_line();
			end else if (ch == CH_RETURN) begin
				col_now = 0;
			end else if (ch == CH_TAB) begin
				stop = (col_now / TAB_STOP + 1) * TAB_STOP;
				while (col_now < stop && col_now < COLS) begin
					screen[row_now * COLS + col_now] = make_cell(CH_SPACE);
					col_now++;
				end
				if (col_now >= COLS)
					new_line();
			end else if (ch == CH_BACKSPACE) begin
				if (col_now > 0) begin
					col_now--;
				end else if (row_now > 0) begin
					row_now--;
					col_now = COLS - 1;
				end
				screen[row_now * COLS + col_now] = make_cell(CH_SPACE);
			end else begin
				screen[row_now * COLS + col_now] = make_cell(ch);
				col_now++;
				if (col_now >= COLS)
					new_line();
			end
		endfunction

		// apply one accepted command and queue the view it must produce
		function void note_command(func_t f, logic [CHAR_W-1:0] ch,
				logic [SEL_W-1:0] rs, logic [SEL_W-1:0] cs);
			console_view_t v;
			int r;
			int c;
			r = (rs >= ROWS) ? ROWS - 1 : int'(rs);
			c = (cs >= COLS) ? COLS - 1 : int'(cs);
			v.code = '0;
			v.fore = '0;
			v.back = '0;
			case (f)
				FN_PUT: begin
					put_char(ch);
				end
				FN_SET: begin
					row_now = r;
					col_now = c;
				end
				FN_CLR: begin
					foreach (screen[i])
						screen[i] = make_cell(CH_SPACE);
					row_now = 0;
					col_now = 0;
					clears++;
				end
				default: begin
					v.code = screen[r * COLS + c].code;
					v.fore = screen[r * COLS + c].fore;
					v.back = screen[r * COLS + c].back;
					reads++;
				end
			endcase
			v.row = row_now[CROW_W-1:0];
			v.col = col_now[CCOL_W-1:0];
			v.pos = CPOS_W'(row_now * COLS + col_now);
			owed.push_back(v);
			commands++;
		endfunction

		function void check_result(console_view_t got);
			console_view_t want;
			results++;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing owed", results);
				return;
			end
			want = owed.pop_front();
			if (got.code !== want.code || got.fore !== want.fore || got.back !== want.back ||
					got.row !== want.row || got.col !== want.col || got.pos !== want.pos) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d mismatch: char %h/%h fore %h/%h back %h/%h (exp/got)",
						results, want.code, got.code, want.fore, got.fore,
						want.back, got.back);
					$display("  cursor row %0d/%0d col %0d/%0d pos %0d/%0d (exp/got)",
						want.row, got.row, want.col, got.col, want.pos, got.pos);
				end
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [FUNC_W-1:0]    func;
	logic [CHAR_W-1:0]    char_code;
	logic [SEL_W-1:0]     row_sel;
	logic [SEL_W-1:0]     col_sel;
	logic                 out_valid;
	logic                 out_stall;
	logic [CHAR_W-1:0]    cell_char;
	logic [COLOR_W-1:0]   cell_fore;
	logic [COLOR_W-1:0]   cell_back;
	logic [CROW_W-1:0]    cursor_row;
	logic [CCOL_W-1:0]    cursor_col;
	logic [CPOS_W-1:0]    cursor_pos;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COLOR_W-1:0]   cfg_data;

	console_scoreboard board = new();
	int sender_gap_pct;
	int receiver_stall_pct;
	int idle_cycles;

	text_console_engine_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.char_code  (char_code),
		.row_sel    (row_sel),
		.col_sel    (col_sel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cell_char  (cell_char),
		.cell_fore  (cell_fore),
		.cell_back  (cell_back),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.cursor_pos (cursor_pos),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// receiver stall, changed on the falling edge
	always @(negedge clk) begin
		out_stall <= (receiver_stall_pct > 0) && ($urandom_range(99) < receiver_stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		console_view_t got;
		if (out_valid && !out_stall) begin
			got.code = cell_char;
			got.fore = cell_fore;
			got.back = cell_back;
			got.row  = cursor_row;
			got.col  = cursor_col;
			got.pos  = cursor_pos;
			board.check_result(got);
		end
	end

	// watchdog: cycles without any accepted item on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// one command item; starts and ends on a falling edge
	task automatic send_item(func_t f, logic [CHAR_W-1:0] ch,
			logic [SEL_W-1:0] rs, logic [SEL_W-1:0] cs);
		while (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		func      <= f;
		char_code <= ch;
		row_sel   <= rs;
		col_sel   <= cs;
		do
			@(posedge clk);
		while (in_stall);
		board.note_command(f, ch, rs, cs);
		@(negedge clk);
	endtask

	// colours change only with nothing in flight
	task automatic write_colours(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FORE;
		cfg_data  <= fg;
		@(posedge clk);
		board.set_colour(REG_FORE, fg);
		@(negedge clk);
		cfg_index <= REG_BACK;
		cfg_data  <= bg;
		@(posedge clk);
		board.set_colour(REG_BACK, bg);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// edge cases of the cursor, control characters and clamping
	task automatic run_directed();
		send_item(FN_READ, 8'd0, 8'd0, 8'd0);
		send_item(FN_PUT, 8'd65, 8'd0, 8'd0);
		send_item(FN_PUT, 8'd0, 8'd255, 8'd255);
		send_item(FN_PUT, 8'd255, 8'd0, 8'd0);
		send_item(FN_PUT, CH_TAB, 8'd0, 8'd0);
		send_item(FN_PUT, CH_RETURN, 8'd0, 8'd0);
		send_item(FN_PUT, CH_NEWLINE, 8'd0, 8'd0);
		send_item(FN_PUT, CH_BACKSPACE, 8'd0, 8'd0);
		send_item(FN_SET, 8'd0, 8'd0, 8'd0);
		send_item(FN_PUT, CH_BACKSPACE, 8'd0, 8'd0);
		send_item(FN_SET, 8'd0, 8'd5, 8'd0);
		send_item(FN_PUT, CH_BACKSPACE, 8'd0, 8'd0);
		send_item(FN_SET, 8'd0, 8'd3, 8'd78);
		send_item(FN_PUT, CH_TAB, 8'd0, 8'd0);
		send_item(FN_READ, 8'd0, 8'd3, 8'd79);
		send_item(FN_SET, 8'd0, 8'd255, 8'd255);
		send_item(FN_PUT, 8'd90, 8'd0, 8'd0);
		send_item(FN_READ, 8'd0, 8'd255, 8'd255);
		send_item(FN_SET, 8'd0, 8'd24, 8'd10);
		send_item(FN_PUT, CH_NEWLINE, 8'd0, 8'd0);
		send_item(FN_READ, 8'd0, 8'd0, 8'd0);
		send_item(FN_CLR, 8'd170, 8'd85, 8'd170);
		send_item(FN_READ, 8'd0, 8'd23, 8'd0);
		send_item(FN_SET, 8'd0, 8'd2, 8'd3);
		send_item(FN_READ, 8'd0, 8'd2, 8'd3);
	endtask

	// weighted random command; rows near the bottom and columns near the
	// row end come up often so wraps, tabs and scrolls get exercised
	task automatic random_command();
		int pick;
		logic [CHAR_W-1:0] ch;
		logic [SEL_W-1:0]  rs;
		logic [SEL_W-1:0]  cs;
		pick = $urandom_range(999);
		ch = CHAR_W'($urandom_range(255));
		rs = SEL_W'($urandom_range(255));
		cs = SEL_W'($urandom_range(255));
		if (pick < 10) begin
			send_item(FN_CLR, ch, rs, cs);
		end else if (pick < 560) begin
			case ($urandom_range(9))
				0: ch = CH_NEWLINE;
				1: ch = CH_RETURN;
				2: ch = CH_TAB;
				3: ch = CH_BACKSPACE;
				default: ch = CHAR_W'($urandom_range(255));
			endcase
			send_item(FN_PUT, ch, rs, cs);
		end else begin
			if ($urandom_range(9) != 0) begin
				rs = SEL_W'(($urandom_range(9) < 3) ? ROWS - 1 : $urandom_range(ROWS - 1));
				cs = SEL_W'(($urandom_range(3) == 0) ? $urandom_range(COLS - 1, COLS - 4)
					: $urandom_range(COLS - 1));
			end
			send_item((pick < 720) ? FN_SET : FN_READ, ch, rs, cs);
		end
	endtask

	initial begin
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		func               = FN_PUT;
		char_code          = '0;
		row_sel            = '0;
		col_sel            = '0;
		cfg_we             = 1'b0;
		cfg_index          = REG_FORE;
		cfg_data           = '0;
		sender_gap_pct     = 0;
		receiver_stall_pct = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();

		// phases: idling pattern cycles, colours walk through the extremes
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin fg = FORE_RST; bg = BACK_RST; end
				1: begin fg = 4'hF; bg = 4'hF; end
				2: begin fg = 4'h0; bg = 4'h0; end
				3: begin fg = 4'h0; bg = 4'hF; end
				4: begin fg = 4'hF; bg = 4'h0; end
				default: begin
					fg = COLOR_W'($urandom_range(15));
					bg = COLOR_W'($urandom_range(15));
				end
			endcase
			if (phase > 0)
				write_colours(fg, bg);
			case (phase % 4)
				0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_gap_pct = 63; receiver_stall_pct = 0;  end
				2: begin sender_gap_pct = 0;  receiver_stall_pct = 63; end
				default: begin sender_gap_pct = 12; receiver_stall_pct = 12; end
			endcase
			repeat (PER_PHASE) random_command();
		end

		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("covered %0d commands in %0d phases: %0d reads, %0d scrolls, %0d clears",
			board.commands, PHASES, board.reads, board.scrolls, board.clears);
		$display("%0d results checked, %0d mismatches, %0d still owed",
			board.results, board.mismatches, board.pending());
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
design/tce_pkg.sv
design/tce_cell_ram.sv
design/text_console_engine_top.sv
tb/sv/tb_text_console_engine_top.sv
